[rtl/mtf_pkg.sv]
// Shared types and constants for the move-to-front order list.
package mtf_pkg;

    localparam int ID_W = 7;

    typedef enum logic [1:0] {
        OP_TOUCH   = 2'd0,
        OP_EMIT    = 2'd1,
        OP_RESTORE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_TOUCH,
        CMD_RESTORE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        cell_cmd_t         cmd;
        logic [ID_W-1:0]   id;
    } cell_ctrl_t;

endpackage

[rtl/mtf_cell.sv]
// One position of the order list: holds an id, compares, and shifts with its neighbors.
module mtf_cell
    import mtf_pkg::*;
#(
    parameter logic [ID_W-1:0] INIT_ID = 7'd1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  cell_ctrl_t      ctrl,
    input  logic [ID_W-1:0] front_value,
    input  logic [ID_W-1:0] back_value,
    input  logic            found_behind,
    output logic [ID_W-1:0] value,
    output logic            found_here
);

    logic [ID_W-1:0] value_reg;
    logic [ID_W-1:0] value_next;

    assign value      = value_reg;
    assign found_here = found_behind | (value_reg == ctrl.id);

    always_comb begin
        value_next = value_reg;
        case (ctrl.cmd)
            CMD_TOUCH: begin
                if (found_here) begin
                    value_next = front_value;
                end
            end
            CMD_RESTORE: value_next = INIT_ID;
            CMD_ROTATE:  value_next = back_value;
            default:     value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= INIT_ID;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule

[rtl/move_to_front_order_list_top.sv]
// Top level of the move-to-front order list: cell chain, emit sequencer and output register.
// The order is held in a row of MAX_ENTRIES cells, front at cell 0. A touch beat or a restore
// beat leaves the block idle, so the next beat can follow in the cycle after. An emit beat
// rotates the whole chain once around, one position per cycle except while a result beat
// waits on the result side and positions remain to be sent, and the block takes no new
// beat until the rotation is done; the first min(entry_count, MAX_ENTRIES) positions go
// out as result beats during that rotation, the last one marked, and the chain is back in
// its original order when the next beat is taken.
// After reset the order is ascending at once; no clearing pass is needed.
module move_to_front_order_list_top
    import mtf_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] cfg_entry_count,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_operation,
    input  logic [ID_W-1:0] s_entry_id,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [ID_W-1:0] m_entry_id_out,
    output logic            m_last
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_ENTRIES - 1);

    logic [ID_W-1:0]  entry_count_reg;
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] emit_n_reg, emit_n_next;
    logic             m_valid_reg, m_valid_next;
    logic [ID_W-1:0]  m_entry_id_reg, m_entry_id_next;
    logic             m_last_reg, m_last_next;

    logic [ID_W-1:0]  eff_count;
    logic             accept;
    logic             touch_ok;
    logic             out_free;
    logic             emitting;
    logic             rotate;
    logic [CNT_W-1:0] cnt_inc;
    cell_ctrl_t       ctrl;

    logic [ID_W-1:0]  cell_value [MAX_ENTRIES];
    logic             cell_found [MAX_ENTRIES];

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_entry_id_out = m_entry_id_reg;
    assign m_last         = m_last_reg;

    assign eff_count = (entry_count_reg > MAX_ID) ? MAX_ID : entry_count_reg;
    assign accept    = s_valid & s_ready;
    assign touch_ok  = (s_entry_id != '0) && (s_entry_id <= eff_count);
    assign out_free  = !m_valid_reg || m_ready;
    assign emitting  = (cnt_reg < emit_n_reg);
    assign rotate    = (state_reg == ST_EMIT) && (!emitting || out_free);
    assign cnt_inc   = cnt_reg + 1'b1;

    always_comb begin
        ctrl.cmd = CMD_HOLD;
        ctrl.id  = s_entry_id;
        if (rotate) begin
            ctrl.cmd = CMD_ROTATE;
        end else if (accept) begin
            case (op_t'(s_operation))
                OP_TOUCH: begin
                    if (touch_ok) begin
                        ctrl.cmd = CMD_TOUCH;
                    end
                end
                OP_RESTORE: ctrl.cmd = CMD_RESTORE;
                default:    ctrl.cmd = CMD_HOLD;
            endcase
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [ID_W-1:0] front_value;
        logic [ID_W-1:0] back_value;
        logic            found_behind;

        if (i == 0) begin : g_front
            assign front_value = ctrl.id;
        end else begin : g_mid_front
            assign front_value = cell_value[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_back
            assign back_value   = cell_value[0];
            assign found_behind = 1'b0;
        end else begin : g_mid_back
            assign back_value   = cell_value[i+1];
            assign found_behind = cell_found[i+1];
        end

        mtf_cell #(
            .INIT_ID(ID_W'(i + 1))
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .front_value (front_value),
            .back_value  (back_value),
            .found_behind(found_behind),
            .value       (cell_value[i]),
            .found_here  (cell_found[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        emit_n_next     = emit_n_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_entry_id_next = m_entry_id_reg;
        m_last_next     = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (op_t'(s_operation) == OP_EMIT)) begin
                    state_next  = ST_EMIT;
                    cnt_next    = '0;
                    emit_n_next = eff_count[CNT_W-1:0];
                end
            end
            ST_EMIT: begin
                if (rotate) begin
                    if (emitting) begin
                        m_valid_next    = 1'b1;
                        m_entry_id_next = cell_value[0];
                        m_last_next     = (cnt_inc == emit_n_reg);
                    end
                    if (cnt_reg == LAST_STEP) begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            emit_n_reg      <= '0;
            m_valid_reg     <= 1'b0;
            entry_count_reg <= 7'd64;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            emit_n_reg  <= emit_n_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                entry_count_reg <= cfg_entry_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_entry_id_reg <= m_entry_id_next;
        m_last_reg     <= m_last_next;
    end

`ifndef SYNTHESIS
    a_restore_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_RESTORE)) |=> (cell_value[0] == ID_W'(1)))
        else $error("Front cell does not hold id 1 after a restore beat.");

    a_touch_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_TOUCH) && touch_ok)
            |=> (cell_value[0] == $past(s_entry_id)))
        else $error("Touched id did not move to the front cell.");

    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg && (state_reg == ST_EMIT) && (cnt_reg != '0))
            |-> (cnt_reg >= emit_n_reg))
        else $error("Last beat shown before all positions were emitted.");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("Rotation counter not cleared while idle.");
`endif

endmodule

[sim/move_to_front_order_list_top_test.sv]
// Self-checking testbench for the move-to-front order list, with its own recency-order predictor.
module move_to_front_order_list_top_test;
    import mtf_pkg::*;

    localparam int ENTRIES = 64;
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES = 10;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] id;
    } order_op_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            last;
    } order_beat_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_entry_count = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic [1:0]      s_operation = '0;
    logic [ID_W-1:0] s_entry_id = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic [ID_W-1:0] m_entry_id_out;
    logic            m_last;

    order_op_t       pending_ops[$];
    order_beat_t     expected_order_beats[$];
    order_op_t       next_op;
    order_beat_t     oldest_beat;
    logic [ID_W-1:0] predicted_order[ENTRIES];
    logic [ID_W-1:0] predicted_count;

    int unsent_ops = 0;
    int ops_offered = 0;
    int ops_taken = 0;
    int cfg_taken = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int phase_counts[PHASES] = '{64, 3, 17, 127, 40, 2, 64, 1, 0, 64};

    always #5 aclk = ~aclk;

    move_to_front_order_list_top #(
        .MAX_ENTRIES(ENTRIES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_entry_count(cfg_entry_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_entry_id     (s_entry_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_id_out (m_entry_id_out),
        .m_last         (m_last)
    );

    function automatic int active_entries(input logic [ID_W-1:0] count);
        return (count > ENTRIES) ? ENTRIES : int'(count);
    endfunction

    function automatic void restore_predicted_order();
        int i;
        for (i = 0; i < ENTRIES; i++) begin
            predicted_order[i] = ID_W'(i + 1);
        end
    endfunction

    function automatic void predict_order_op(input op_t op, input logic [ID_W-1:0] id);
        int n;
        int pos;
        int i;
        order_beat_t beat;
        n = active_entries(predicted_count);
        case (op)
            OP_TOUCH: begin
                if (id != 0 && id <= n) begin
                    pos = -1;
                    for (i = 0; i < ENTRIES; i++) begin
                        if (pos < 0 && predicted_order[i] == id) pos = i;
                    end
                    for (i = pos; i > 0; i--) begin
                        predicted_order[i] = predicted_order[i - 1];
                    end
                    predicted_order[0] = id;
                end
            end
            OP_EMIT: begin
                for (i = 0; i < n; i++) begin
                    beat.id   = predicted_order[i];
                    beat.last = (i == n - 1);
                    expected_order_beats.insert(expected_order_beats.size(), beat);
                end
            end
            OP_RESTORE: begin
                restore_predicted_order();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic order_op_t random_order_op(input int n);
        order_op_t item;
        int pick;
        pick = $urandom_range(99);
        item.id = ID_W'($urandom);
        if (pick < 70) begin
            item.op = OP_TOUCH;
            if (n > 0) item.id = ID_W'($urandom_range(n, 1));
        end else if (pick < 78) begin
            item.op = OP_TOUCH;
        end else if (pick < 92) begin
            item.op = OP_EMIT;
        end else if (pick < 96) begin
            item.op = OP_RESTORE;
        end else begin
            item.op = OP_NONE;
        end
        return item;
    endfunction

    task automatic push_op(input op_t op, input logic [ID_W-1:0] id);
        order_op_t item;
        item.op = op;
        item.id = id;
        pending_ops.insert(pending_ops.size(), item);
        unsent_ops++;
    endtask

    task automatic push_random_ops(input int real_ops, input int n);
        order_op_t item;
        int done;
        done = 0;
        while (done < real_ops) begin
            item = random_order_op(n);
            push_op(item.op, item.id);
            if (!(item.op == OP_NONE || (item.op == OP_TOUCH && (item.id == 0 || item.id > n))))
                done++;
        end
    endtask

    task automatic wait_drained();
        while (unsent_ops != 0 || expected_order_beats.size() != 0) @(negedge aclk);
    endtask

    task automatic write_entry_count(input logic [ID_W-1:0] value);
        int target;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        target = cfg_taken + 1;
        cfg_valid <= 1'b1;
        cfg_entry_count <= value;
        do @(negedge aclk); while (cfg_taken < target);
        cfg_valid <= 1'b0;
        cfg_entry_count <= ID_W'($urandom);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin send_gap_pct = 73; recv_stall_pct = 0; end
            2: begin send_gap_pct = 0; recv_stall_pct = 73; end
            3: begin send_gap_pct = 6; recv_stall_pct = 6; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    always @(negedge aclk) begin
        if (aresetn && !(s_valid && ops_taken != ops_offered)) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_op = pending_ops.pop_front();
                s_valid <= 1'b1;
                s_operation <= next_op.op;
                s_entry_id <= next_op.id;
                ops_offered <= ops_offered + 1;
            end else begin
                s_valid <= 1'b0;
                s_operation <= 2'($urandom);
                s_entry_id <= ID_W'($urandom);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_order_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: id %0d last %0b",
                                 m_entry_id_out, m_last);
                end else begin
                    oldest_beat = expected_order_beats.pop_front();
                    if (m_entry_id_out !== oldest_beat.id || m_last !== oldest_beat.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected id %0d last %0b, got id %0d last %0b",
                                     oldest_beat.id, oldest_beat.last, m_entry_id_out, m_last);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_taken <= cfg_taken + 1;
                predicted_count = cfg_entry_count;
            end
            if (s_valid && s_ready) begin
                ops_taken <= ops_taken + 1;
                unsent_ops--;
                predict_order_op(op_t'(s_operation), s_entry_id);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int p;
        predicted_count = ID_W'(ENTRIES);
        restore_predicted_order();
        set_idling(0);
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        push_op(OP_EMIT, ID_W'($urandom));
        push_op(OP_TOUCH, 7'd64);
        push_op(OP_TOUCH, 7'd1);
        push_op(OP_TOUCH, 7'd0);
        push_op(OP_TOUCH, 7'd65);
        push_op(OP_TOUCH, 7'd127);
        push_op(OP_NONE, ID_W'($urandom));
        push_op(OP_EMIT, ID_W'($urandom));
        push_op(OP_TOUCH, 7'd33);
        push_op(OP_EMIT, ID_W'($urandom));
        push_op(OP_RESTORE, ID_W'($urandom));
        push_op(OP_EMIT, ID_W'($urandom));
        wait_drained();

        write_entry_count(7'd1);
        push_op(OP_TOUCH, 7'd1);
        push_op(OP_TOUCH, 7'd2);
        push_op(OP_EMIT, ID_W'($urandom));
        write_entry_count(7'd0);
        push_op(OP_TOUCH, 7'd1);
        push_op(OP_EMIT, ID_W'($urandom));
        push_op(OP_RESTORE, ID_W'($urandom));
        write_entry_count(7'd127);
        push_op(OP_TOUCH, 7'd64);
        push_op(OP_EMIT, ID_W'($urandom));
        write_entry_count(7'd64);
        push_op(OP_TOUCH, 7'd40);
        push_op(OP_TOUCH, 7'd50);
        write_entry_count(7'd5);
        push_op(OP_EMIT, ID_W'($urandom));

        for (p = 0; p < PHASES; p++) begin
            write_entry_count(ID_W'(phase_counts[p]));
            set_idling(p % 4);
            if (phase_counts[p] == 0) begin
                push_random_ops(4, 0);
            end else begin
                push_random_ops(8, active_entries(ID_W'(phase_counts[p])));
                if (p == 2) wait_drained();
                push_random_ops(8, active_entries(ID_W'(phase_counts[p])));
            end
        end

        // The receiver holds off while several emit beats queue up behind the first one.
        write_entry_count(7'd64);
        set_idling(0);
        hold_requests++;
        for (p = 0; p < 4; p++) begin
            push_op(OP_EMIT, ID_W'($urandom));
            push_random_ops(5, ENTRIES);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
rtl/mtf_pkg.sv
rtl/mtf_cell.sv
rtl/move_to_front_order_list_top.sv
sim/move_to_front_order_list_top_test.sv
